// ----- rtl/core/sprq_pkg.sv -----
// Shared types and constants for the strict-priority ring queues.
`default_nettype none

package sprq_pkg;

  // Fixed field widths of the channel beats
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_HANDLE_W = 32;

  // Result queue in the back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH      = 2'd0,
    FN_POP_PRIO  = 2'd1,
    FN_POP_NAMED = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POPPED    = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Classified beat handed from front to back, aligned with the RAM read data
  typedef struct packed {
    logic                 valid;
    status_e              status;
    logic [LEVEL_W-1:0]   level;
  } issue_t;

endpackage

`default_nettype wire

// ----- rtl/core/sprq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sprq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/sprq_front.sv -----
// Front end: classifies each beat, owns head/tail pointers, drives the stores.
`default_nettype none

module sprq_front #(
  parameter int unsigned NUM_LEVELS = 2,
  parameter int unsigned RING_DEPTH = 16,
  parameter int unsigned ADDR_W     = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [sprq_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [sprq_pkg::LEVEL_W-1:0]  level_i,
  output logic                               ram_we_o,
  output logic      [ADDR_W-1:0]             ram_waddr_o,
  output logic                               ram_re_o,
  output logic      [ADDR_W-1:0]             ram_raddr_o,
  output sprq_pkg::issue_t                   issue_o
);

  import sprq_pkg::*;

  localparam int unsigned LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned PW = $clog2(RING_DEPTH);

  logic [PW-1:0]         head_q [NUM_LEVELS];
  logic [PW-1:0]         head_d [NUM_LEVELS];
  logic [PW-1:0]         tail_q [NUM_LEVELS];
  logic [PW-1:0]         tail_d [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty;
  logic                  prio_hit;
  logic [LW-1:0]         prio_lvl;
  logic                  lvl_ok;
  logic [LW-1:0]         lvl_idx;
  logic [PW-1:0]         tail_next;
  issue_t                issue_d;
  issue_t                issue_q;

  // Ring pointer step with wrap at the ring depth
  function automatic logic [PW-1:0] ring_adv(input logic [PW-1:0] p);
    ring_adv = (p == PW'(RING_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  // Flat store address of one ring slot
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LW-1:0] lv,
                                                  input logic [PW-1:0] p);
    slot_addr = ADDR_W'(ADDR_W'(lv) * ADDR_W'(RING_DEPTH) + ADDR_W'(p));
  endfunction

  // Occupancy flags and priority encoder, level 0 wins
  always_comb begin
    prio_hit = 1'b0;
    prio_lvl = '0;
    for (int i = 0; i < int'(NUM_LEVELS); i++) begin
      nonempty[i] = (head_q[i] != tail_q[i]);
    end
    for (int i = int'(NUM_LEVELS) - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        prio_hit = 1'b1;
        prio_lvl = LW'(i);
      end
    end
  end

  assign lvl_ok  = (4'(level_i) < 4'(NUM_LEVELS));
  assign lvl_idx = level_i[LW-1:0];

  // Classification and pointer updates
  always_comb begin
    head_d         = head_q;
    tail_d         = tail_q;
    ram_we_o       = 1'b0;
    ram_waddr_o    = '0;
    ram_re_o       = 1'b0;
    ram_raddr_o    = '0;
    tail_next      = '0;
    issue_d.valid  = accept_i;
    issue_d.status = ST_EMPTY;
    issue_d.level  = '0;
    unique case (func_e'(func_i))
      FN_PUSH: begin
        if (lvl_ok) begin
          tail_next = ring_adv(tail_q[lvl_idx]);
        end
        if (lvl_ok && (tail_next != head_q[lvl_idx])) begin
          issue_d.status = ST_PUSH_OK;
          ram_we_o       = accept_i;
          ram_waddr_o    = slot_addr(lvl_idx, tail_q[lvl_idx]);
          if (accept_i) begin
            tail_d[lvl_idx] = tail_next;
          end
        end else begin
          issue_d.status = ST_PUSH_FULL;
        end
      end
      FN_POP_PRIO: begin
        if (prio_hit) begin
          issue_d.status = ST_POPPED;
          issue_d.level  = LEVEL_W'(prio_lvl);
          ram_re_o       = accept_i;
          ram_raddr_o    = slot_addr(prio_lvl, head_q[prio_lvl]);
          if (accept_i) begin
            head_d[prio_lvl] = ring_adv(head_q[prio_lvl]);
          end
        end
      end
      FN_POP_NAMED: begin
        if (lvl_ok && nonempty[lvl_idx]) begin
          issue_d.status = ST_POPPED;
          issue_d.level  = level_i;
          ram_re_o       = accept_i;
          ram_raddr_o    = slot_addr(lvl_idx, head_q[lvl_idx]);
          if (accept_i) begin
            head_d[lvl_idx] = ring_adv(head_q[lvl_idx]);
          end
        end
      end
      default: begin
        issue_d.status = ST_EMPTY;
      end
    endcase
  end

  // Pointer and issue registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_LEVELS); i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      issue_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      issue_q <= issue_d;
    end
  end

  assign issue_o = issue_q;

endmodule

`default_nettype wire

// ----- rtl/core/sprq_back.sv -----
// Back end: forms result beats from the issue and store read, queues them.
`default_nettype none

module sprq_back #(
  parameter int unsigned STORE_W = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  sprq_pkg::issue_t                       issue_i,
  input  wire logic [STORE_W-1:0]                handler_i,
  input  wire logic [STORE_W-1:0]                argument_i,
  input  wire logic                              pop_i,
  output logic                                   space_o,
  output logic                                   empty_o,
  output logic      [sprq_pkg::STATUS_W-1:0]     status_o,
  output logic      [sprq_pkg::LEVEL_W-1:0]      popped_level_o,
  output logic      [sprq_pkg::OUT_HANDLE_W-1:0] out_handler_o,
  output logic      [sprq_pkg::OUT_HANDLE_W-1:0] out_argument_o
);

  import sprq_pkg::*;

  status_e            q_status   [QUEUE_DEPTH];
  logic [LEVEL_W-1:0] q_level    [QUEUE_DEPTH];
  logic [STORE_W-1:0] q_handler  [QUEUE_DEPTH];
  logic [STORE_W-1:0] q_argument [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d;
  logic [QPTR_W-1:0]  rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               wr_en;
  logic               rd_en;
  logic               popped;

  assign wr_en  = issue_i.valid;
  assign rd_en  = pop_i && (cnt_q != '0);
  assign popped = (issue_i.status == ST_POPPED);

  // Pointer and fill count bookkeeping
  always_comb begin
    wr_d  = wr_en ? QPTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = rd_en ? QPTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = QCNT_W'(cnt_q + QCNT_W'(wr_en) - QCNT_W'(rd_en));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage; handles zeroed unless the beat popped an entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_status[wr_q]   <= issue_i.status;
      q_level[wr_q]    <= issue_i.level;
      q_handler[wr_q]  <= popped ? handler_i : '0;
      q_argument[wr_q] <= popped ? argument_i : '0;
    end
  end

  // Room for the in-flight beat plus a new one
  assign space_o = (QCNT_W'(cnt_q + QCNT_W'(issue_i.valid)) < QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

  assign status_o       = q_status[rd_q];
  assign popped_level_o = q_level[rd_q];
  assign out_handler_o  = OUT_HANDLE_W'(q_handler[rd_q]);
  assign out_argument_o = OUT_HANDLE_W'(q_argument[rd_q]);

endmodule

`default_nettype wire

// ----- rtl/core/strict_priority_ring_queues.sv -----
// Top level of the strict-priority ring queues: front end, handle stores, back end.
//
//   channel   direction  handshake        beat
//   request   in         push_i / full_o  func, level, handler_handle, argument_handle
//   result    out        pop_i / empty_o  status, popped_level, out_handler, out_argument
//
// One request beat is taken per cycle while full_o is low; its store read and issue beat are
// registered at the accepting edge, and the result queue is written from them, after which
// the result is on the result ports and can be popped.
// Reset clears the ring pointers and the result queue; the handle stores are not cleared.
// full_o rises when the four-entry result queue plus the beat in flight would overflow,
// so a stalled result side holds back the request side after at most four beats.
`default_nettype none

module strict_priority_ring_queues #(
  parameter int unsigned NUM_LEVELS   = 2,
  parameter int unsigned RING_DEPTH   = 16,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  output logic                                   full_o,
  input  wire logic [sprq_pkg::FUNC_W-1:0]       func_i,
  input  wire logic [sprq_pkg::LEVEL_W-1:0]      level_i,
  input  wire logic [sprq_pkg::OUT_HANDLE_W-1:0] handler_handle_i,
  input  wire logic [sprq_pkg::OUT_HANDLE_W-1:0] argument_handle_i,
  input  wire logic                              pop_i,
  output logic                                   empty_o,
  output logic      [sprq_pkg::STATUS_W-1:0]     status_o,
  output logic      [sprq_pkg::LEVEL_W-1:0]      popped_level_o,
  output logic      [sprq_pkg::OUT_HANDLE_W-1:0] out_handler_o,
  output logic      [sprq_pkg::OUT_HANDLE_W-1:0] out_argument_o
);

  import sprq_pkg::*;

  localparam int unsigned STORE_W = (HANDLE_WIDTH < OUT_HANDLE_W) ? HANDLE_WIDTH
                                                                  : OUT_HANDLE_W;
  localparam int unsigned SLOTS   = NUM_LEVELS * RING_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(SLOTS);

  logic               accept;
  logic               space;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [STORE_W-1:0] rd_handler;
  logic [STORE_W-1:0] rd_argument;
  issue_t             issue;

  assign accept = push_i && space;
  assign full_o = !space;

  // Classification and ring pointers
  sprq_front #(
    .NUM_LEVELS(NUM_LEVELS),
    .RING_DEPTH(RING_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .level_i    (level_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .issue_o    (issue)
  );

  // Handler and argument stores
  sprq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SLOTS),
    .ADDR_W(ADDR_W)
  ) u_handler_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(handler_handle_i[STORE_W-1:0]),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_handler)
  );

  sprq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SLOTS),
    .ADDR_W(ADDR_W)
  ) u_argument_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(argument_handle_i[STORE_W-1:0]),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_argument)
  );

  // Result formation and output queue
  sprq_back #(
    .STORE_W(STORE_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .handler_i     (rd_handler),
    .argument_i    (rd_argument),
    .pop_i         (pop_i),
    .space_o       (space),
    .empty_o       (empty_o),
    .status_o      (status_o),
    .popped_level_o(popped_level_o),
    .out_handler_o (out_handler_o),
    .out_argument_o(out_argument_o)
  );

`ifndef NO_ASSERTIONS
  // Every accepted beat reaches the back end in the following cycle
  a_accept_issues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> issue.valid)
    else $error("accepted beat did not issue");

  // A store slot is never read and written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and write in one cycle");

  // Popped results come only from existing levels
  a_popped_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o == ST_POPPED) |-> (4'(popped_level_o) < 4'(NUM_LEVELS)))
    else $error("popped level out of range");

  // Results that popped nothing carry zero fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != ST_POPPED) |->
      (popped_level_o == '0 && out_handler_o == '0 && out_argument_o == '0))
    else $error("non-pop result carries data");
`endif

endmodule

`default_nettype wire
